// ===== rtl/core/hepsel_pkg.sv =====
package hepsel_pkg;

    // Partition and vertex space
    localparam int NUM_PARTS = 16;
    localparam int PART_W    = $clog2(NUM_PARTS);
    localparam int NUM_VERTS = 65536;
    localparam int VERT_W    = $clog2(NUM_VERTS);

    // Field widths
    localparam int VID_W     = 16;
    localparam int DEG_W     = 16;
    localparam int LOAD_W    = 32;
    localparam int WEIGHT_W  = 16;
    localparam int PIU_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Score arithmetic (Q6.16)
    localparam int FRAC_W    = 16;
    localparam int SCORE_W   = 22;
    localparam int BAL_FRAC  = 12;
    localparam int PROD_W    = SCORE_W + BAL_FRAC;
    localparam int G_W       = FRAC_W + 2;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [G_W-1:0]     G_TWO     = G_W'(2) << FRAC_W;
    localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};

    // Sequencing
    localparam int DIV_STEPS   = LOAD_W + FRAC_W;
    localparam int RATIO_STEPS = DEG_W + FRAC_W;
    localparam int RATIO_CNT_W = $clog2(RATIO_STEPS + 1);
    localparam int SEQ_MAX     = (DIV_STEPS > NUM_PARTS) ? DIV_STEPS : NUM_PARTS;
    localparam int SEQ_CNT_W   = $clog2(SEQ_MAX + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE   = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd4096;
    localparam logic [LOAD_W-1:0]   LIMIT_RST  = {LOAD_W{1'b1}};
    localparam logic [PIU_W-1:0]    PIU_RST    = 5'd16;

    // Best-so-far token passed down the cell row
    typedef struct packed {
        logic               none;
        logic               full;
        logic [SCORE_W-1:0] score;
        logic [PART_W-1:0]  idx;
        logic [LOAD_W-1:0]  load;
    } t_token;

    localparam t_token TOK_NONE = '{none: 1'b1, full: 1'b1, score: '0, idx: '0, load: '0};

    typedef struct packed {
        logic              start;
        logic              step;
        logic              score;
        logic              scan;
        logic              upd;
        logic [PART_W-1:0] sel;
    } t_cell_ctrl;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [LOAD_W-1:0]   limit;
        logic [LOAD_W-1:0]   largest;
        logic [LOAD_W-1:0]   smallest;
        logic [G_W-1:0]      ga;
        logic [G_W-1:0]      gb;
    } t_cell_bus;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCORE,
        ST_SCAN,
        ST_UPDATE,
        ST_SMALL,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/core/hepsel_if.sv =====
interface hepsel_edge_if;
    import hepsel_pkg::*;
    logic             valid;
    logic             ready;
    logic [VID_W-1:0] vertex_a;
    logic [VID_W-1:0] vertex_b;
    logic [DEG_W-1:0] degree_a;
    logic [DEG_W-1:0] degree_b;
    modport source (output valid, vertex_a, vertex_b, degree_a, degree_b, input ready);
    modport sink   (input valid, vertex_a, vertex_b, degree_a, degree_b, output ready);
endinterface

interface hepsel_part_if;
    import hepsel_pkg::*;
    logic              valid;
    logic              ready;
    logic [3:0]        chosen_part;
    logic [LOAD_W-1:0] part_load;
    modport source (output valid, chosen_part, part_load, input ready);
    modport sink   (input valid, chosen_part, part_load, output ready);
endinterface

interface hepsel_cfg_if;
    import hepsel_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hepsel_ratio_div.sv =====
module hepsel_ratio_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hepsel_pkg::DEG_W-1:0] i_degree_a,
    input  logic [hepsel_pkg::DEG_W-1:0] i_degree_b,
    output logic [hepsel_pkg::G_W-1:0]  o_ga,
    output logic [hepsel_pkg::G_W-1:0]  o_gb,
    output logic                        o_done
);
    import hepsel_pkg::*;

    // Two restoring dividers, one quotient bit per cycle: (deg << 16) / (deg_a + deg_b)
    logic [RATIO_CNT_W-1:0] r_cnt;
    logic [DEG_W:0]         r_sum;
    logic [DEG_W:0]         r_rem [2];
    logic [RATIO_STEPS-1:0] r_dvd [2];
    logic [DEG_W:0]         r_q   [2];
    logic [DEG_W+1:0]       w_sh  [2];
    logic                   w_ge  [2];
    logic [DEG_W+1:0]       w_rem [2];
    logic [G_W-1:0]         w_g   [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sh[k]  = {r_rem[k], r_dvd[k][RATIO_STEPS-1]};
            w_ge[k]  = w_sh[k] >= {1'b0, r_sum};
            w_rem[k] = w_ge[k] ? (w_sh[k] - {1'b0, r_sum}) : w_sh[k];
            // zero sum: ratio taken as 0
            w_g[k]   = G_TWO - ((r_sum == '0) ? '0 : G_W'(r_q[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= RATIO_CNT_W'(RATIO_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum    <= {1'b0, i_degree_a} + {1'b0, i_degree_b};
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_dvd[0] <= {i_degree_a, {FRAC_W{1'b0}}};
            r_dvd[1] <= {i_degree_b, {FRAC_W{1'b0}}};
            r_q[0]   <= '0;
            r_q[1]   <= '0;
        end else if (r_cnt != '0) begin
            for (int k = 0; k < 2; k++) begin
                r_rem[k] <= w_rem[k][DEG_W:0];
                r_dvd[k] <= r_dvd[k] << 1;
                r_q[k]   <= {r_q[k][DEG_W-1:0], w_ge[k]};
            end
        end
    end

    assign o_ga   = w_g[0];
    assign o_gb   = w_g[1];
    assign o_done = (r_cnt == '0);

endmodule

// ===== rtl/core/hepsel_cell.sv =====
module hepsel_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hepsel_pkg::PART_W-1:0] i_index,
    input  logic                          i_active,
    input  logic                          i_hit_a,
    input  logic                          i_hit_b,
    input  hepsel_pkg::t_cell_ctrl        i_ctrl,
    input  hepsel_pkg::t_cell_bus         i_bus,
    input  hepsel_pkg::t_token            i_tok,
    output hepsel_pkg::t_token            o_tok,
    output logic                          o_eq_small
);
    import hepsel_pkg::*;

    logic [LOAD_W-1:0]    r_load;
    logic [LOAD_W:0]      r_rem;
    logic [LOAD_W:0]      r_den;
    logic [DIV_STEPS-1:0] r_dvd;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_sat;
    logic [SCORE_W-1:0]   r_score;
    logic                 r_full;
    t_token               r_tok;

    logic [LOAD_W-1:0]  w_num;
    logic [LOAD_W:0]    w_den;
    logic [LOAD_W+1:0]  w_sh;
    logic               w_ge;
    logic [LOAD_W+1:0]  w_rem;
    logic [PROD_W+1:0]  w_prod;
    logic               w_ovf;
    logic [SCORE_W-1:0] w_bal;
    logic [SCORE_W+1:0] w_sum;
    logic [SCORE_W-1:0] w_score;
    logic               w_take;
    t_token             w_own;

    always_comb begin
        w_num = (i_bus.largest > r_load) ? (i_bus.largest - r_load) : '0;
        w_den = (i_bus.largest >= i_bus.smallest)
              ? ({1'b0, i_bus.largest - i_bus.smallest} + 1'b1) : (LOAD_W+1)'(1);
        // restoring step; quotient bits feed a shift-add with the weight, MSB first
        w_sh   = {r_rem, r_dvd[DIV_STEPS-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        w_rem  = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
        w_prod = {1'b0, r_prod, 1'b0} + (w_ge ? (PROD_W+2)'(i_bus.weight) : '0);
        w_ovf  = (w_prod[PROD_W+1:PROD_W] != 2'b00);
        w_bal  = r_sat ? SCORE_MAX : r_prod[PROD_W-1:BAL_FRAC];
        w_sum  = (SCORE_W+2)'(w_bal)
               + (i_hit_a ? (SCORE_W+2)'(i_bus.ga) : '0)
               + (i_hit_b ? (SCORE_W+2)'(i_bus.gb) : '0);
        w_score = (r_sat || (w_sum > (SCORE_W+2)'(SCORE_MAX))) ? SCORE_MAX
                                                                : w_sum[SCORE_W-1:0];
        w_own  = '{none: 1'b0, full: r_full, score: r_score, idx: i_index, load: r_load};
        w_take = i_active
              && (i_tok.none || (!r_full && (i_tok.full || (r_score > i_tok.score))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
        end else if (i_ctrl.upd && (i_ctrl.sel == i_index) && (r_load != LOAD_MAX)) begin
            r_load <= r_load + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem  <= '0;
            r_dvd  <= {w_num, {FRAC_W{1'b0}}};
            r_den  <= w_den;
            r_prod <= '0;
            r_sat  <= 1'b0;
        end else if (i_ctrl.step) begin
            r_rem  <= w_rem[LOAD_W:0];
            r_dvd  <= r_dvd << 1;
            r_prod <= w_prod[PROD_W-1:0];
            r_sat  <= r_sat | w_ovf;
        end
        if (i_ctrl.score) begin
            r_score <= w_score;
            r_full  <= (r_load >= i_bus.limit);
        end
        if (i_ctrl.scan) begin
            r_tok <= w_take ? w_own : i_tok;
        end
    end

    assign o_tok      = r_tok;
    assign o_eq_small = i_active && (r_load == i_bus.smallest);

endmodule

// ===== rtl/core/hdrf_edge_partition_select_core.sv =====
// Streaming vertex-cut edge partitioner (HDRF scoring).
// Channels: i_edge takes one edge (two vertex ids and their degrees); o_part
// returns one result per edge: the chosen partition and its edge count after
// the assignment. i_cfg writes balance_weight (0), load_limit (1) and
// parts_in_use (2); it is always ready, and the user must see that it is
// written only while idle; the block does not enforce this. Every channel
// moves a transfer on a clock edge with valid and ready high. One edge is
// in work at a time: a new edge is taken only once the last result has
// been loaded into the output register. The 48-step bit-serial division
// of the balance term inside every partition cell comes first, followed
// by a scan of the best-score token along the cell row and two replica-map
// write-backs. Reset: synchronous, active low. Loads, load extremes and
// registers return to their defaults, then the replica map is cleared one
// vertex per cycle with i_edge.ready low; config writes are taken meanwhile.
// Stall: a result waits in the output register; the next edge is taken and
// worked on, and it holds before its own result until o_part is free.
module hdrf_edge_partition_select_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hepsel_edge_if.sink          i_edge,
    hepsel_part_if.source        o_part,
    hepsel_cfg_if.sink           i_cfg
);
    import hepsel_pkg::*;

    t_state                 r_state, n_state;
    logic [SEQ_CNT_W-1:0]   r_cnt, n_cnt;

    // Configuration
    logic [WEIGHT_W-1:0]    r_weight;
    logic [LOAD_W-1:0]      r_limit;
    logic [PIU_W-1:0]       r_piu;

    // Load extremes shared by all cells
    logic [LOAD_W-1:0]      r_largest;
    logic [LOAD_W-1:0]      r_smallest;

    // Current edge
    logic [VERT_W-1:0]      r_va, r_vb;
    logic [NUM_PARTS-1:0]   r_map_a, r_map_b;
    logic [LOAD_W-1:0]      r_old, r_now;

    // Replica map: one bit per partition for every vertex
    logic [NUM_PARTS-1:0]   r_mem [NUM_VERTS];
    logic [VERT_W-1:0]      r_clr_addr;

    // Result register
    logic                   r_out_valid;
    logic [3:0]             r_out_part;
    logic [LOAD_W-1:0]      r_out_load;

    logic                   w_accept;
    logic                   w_we;
    logic [VERT_W-1:0]      w_waddr;
    logic [NUM_PARTS-1:0]   w_wdata;
    logic                   w_out_load;
    logic [NUM_PARTS-1:0]   w_bit;
    logic [LOAD_W-1:0]      w_inc;
    logic                   w_ratio_done;
    logic [G_W-1:0]         w_ga, w_gb;
    logic [NUM_PARTS-1:0]   w_active;
    logic [NUM_PARTS-1:0]   w_eq;
    t_cell_ctrl             w_ctrl;
    t_cell_bus              w_bus;
    t_token                 w_chain [NUM_PARTS+1];
    t_token                 w_tok;

    assign w_accept = i_edge.valid && i_edge.ready;
    assign w_tok    = w_chain[NUM_PARTS];
    assign w_bit    = NUM_PARTS'(1) << w_tok.idx;
    assign w_inc    = (w_tok.load == LOAD_MAX) ? w_tok.load : (w_tok.load + 1'b1);

    assign w_bus = '{weight: r_weight, limit: r_limit, largest: r_largest,
                     smallest: r_smallest, ga: w_ga, gb: w_gb};

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        i_edge.ready = 1'b0;
        w_ctrl       = '0;
        w_ctrl.sel   = w_tok.idx;
        w_we         = 1'b0;
        w_waddr      = r_va;
        w_wdata      = r_map_a | w_bit;
        w_out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == VERT_W'(NUM_VERTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_edge.ready = 1'b1;
                if (i_edge.valid) begin
                    w_ctrl.start = 1'b1;
                    n_cnt        = SEQ_CNT_W'(DIV_STEPS);
                    n_state      = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt != '0) begin
                    w_ctrl.step = 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                end else if (w_ratio_done) begin
                    n_state = ST_SCORE;
                end
            end
            ST_SCORE: begin
                w_ctrl.score = 1'b1;
                n_cnt        = SEQ_CNT_W'(NUM_PARTS);
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                // token advances one cell per cycle
                if (r_cnt != '0) begin
                    w_ctrl.scan = 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                w_ctrl.upd = 1'b1;
                w_we       = 1'b1;
                n_state    = ST_SMALL;
            end
            ST_SMALL: begin
                // same vertex twice rewrites the same value
                w_we    = 1'b1;
                w_waddr = r_vb;
                w_wdata = r_map_b | w_bit;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || o_part.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- replica map ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_map_a <= r_mem[VERT_W'(i_edge.vertex_a)];
            r_map_b <= r_mem[VERT_W'(i_edge.vertex_b)];
        end
    end

    // ---------------- control and datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= WEIGHT_RST;
            r_limit     <= LIMIT_RST;
            r_piu       <= PIU_RST;
            r_largest   <= '0;
            r_smallest  <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_BALANCE_WEIGHT: r_weight <= i_cfg.data[WEIGHT_W-1:0];
                    CFG_LOAD_LIMIT:     r_limit  <= i_cfg.data[LOAD_W-1:0];
                    CFG_PARTS_IN_USE:   r_piu    <= i_cfg.data[PIU_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == ST_UPDATE) && (w_inc > r_largest)) begin
                r_largest <= w_inc;
            end
            // smallest moves up once no partition in use still holds it
            if ((r_state == ST_SMALL) && (r_old == r_smallest) && (w_eq == '0)
                    && (r_smallest != LOAD_MAX)) begin
                r_smallest <= r_smallest + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_part.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va <= VERT_W'(i_edge.vertex_a);
            r_vb <= VERT_W'(i_edge.vertex_b);
        end
        if (r_state == ST_UPDATE) begin
            r_old <= w_tok.load;
            r_now <= w_inc;
        end
        if (w_out_load) begin
            r_out_part <= 4'(w_tok.idx);
            r_out_load <= r_now;
        end
    end

    assign i_cfg.ready        = 1'b1;
    assign o_part.valid       = r_out_valid;
    assign o_part.chosen_part = r_out_part;
    assign o_part.part_load   = r_out_load;

    // ---------------- shared replica-term divider ----------------
    hepsel_ratio_div u_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_degree_a (i_edge.degree_a),
        .i_degree_b (i_edge.degree_b),
        .o_ga       (w_ga),
        .o_gb       (w_gb),
        .o_done     (w_ratio_done)
    );

    // ---------------- partition cell row ----------------
    assign w_chain[0] = TOK_NONE;

    for (genvar p = 0; p < NUM_PARTS; p++) begin : g_cell
        // parts_in_use of zero still scores partition 0
        assign w_active[p] = (r_piu == '0) ? (p == 0) : (int'(r_piu) > p);

        hepsel_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (PART_W'(p)),
            .i_active   (w_active[p]),
            .i_hit_a    (r_map_a[p]),
            .i_hit_b    (r_map_b[p]),
            .i_ctrl     (w_ctrl),
            .i_bus      (w_bus),
            .i_tok      (w_chain[p]),
            .o_tok      (w_chain[p+1]),
            .o_eq_small (w_eq[p])
        );
    end

    // ---------------- assertions ----------------
    a_winner_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> (!w_tok.none && w_active[w_tok.idx]))
        else $error("winner token is empty or names an unused partition");

    a_ratio_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCORE) |-> w_ratio_done)
        else $error("scoring before replica terms are done");

    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SMALL) |-> ((r_now == r_old + 1'b1) || (r_old == LOAD_MAX)))
        else $error("winner load did not advance by one");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== tb/sv/tb_if.sv =====
`timescale 1ns / 1ps

// The block's interfaces come with the RTL (hepsel_if.sv). This file only
// holds the record of one edge, as the testbench's stimulus queue keeps it.
package tb_edge_pkg;
    typedef struct packed {
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] degree_a;
        logic [15:0] degree_b;
    } t_edge;
endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Edge partition selector testbench.
// A driver feeds edges and config writes from one queue of pending transfers.
// Each edge's expected partition and load is worked out from a model of the
// score and stored. A monitor checks each o_part transfer against the oldest
// stored result. Idle and stall rates change from one phase to the next.
module tb;
    import hepsel_pkg::*;
    import tb_edge_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    hepsel_edge_if edge_ch();
    hepsel_part_if part_ch();
    hepsel_cfg_if  cfg_ch();

    hdrf_edge_partition_select_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_ch.sink),
        .o_part  (part_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Pending transfer: an edge, a config write, or a drain marker. A marker
    // holds the driver until every expected result has come back, then a
    // latency-sized pause, so config is only written while idle.
    typedef enum logic [1:0] {
        OP_EDGE,
        OP_CFG,
        OP_DRAIN
    } t_op;

    typedef struct {
        t_op                  op;
        t_edge                e;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        int                   send_idle;  // percent, sender gaps
        int                   recv_stall; // percent, receiver stalls
    } t_pending;

    typedef struct {
        logic [3:0]  part;
        logic [31:0] load;
    } t_assign;

    t_pending  pending_q[$];
    t_assign   assign_q[$];

    // Predictor state
    logic [15:0] m_weight;
    logic [31:0] m_limit;
    logic [4:0]  m_piu;
    logic [15:0] m_replica[int];
    logic [31:0] m_load[NUM_PARTS];
    logic [31:0] m_largest;
    logic [31:0] m_smallest;

    int errors = 0;
    int cycles = 0;
    int cur_idle = 0;
    int cur_stall = 0;
    bit stim_done = 1'b0;
    int drain_wait = 0;

    function automatic logic [15:0] replica_of(input logic [15:0] v);
        if (m_replica.exists(v))
            return m_replica[v];
        return 16'h0;
    endfunction

    function automatic logic [63:0] g_term(input logic [63:0] deg, input logic [63:0] sum);
        logic [63:0] ratio;
        ratio = 0;
        if (sum != 0)
            ratio = (deg << 16) / sum;
        return 64'd131072 - ratio;
    endfunction

    // Work out one edge's assignment and update the predictor's state.
    function automatic t_assign predict_edge(input t_edge e);
        int          n;
        int          best;
        longint      top_score;
        longint      sc;
        logic [63:0] s, num, den, r, da, db;
        logic [31:0] old_ld, now_ld;
        logic [15:0] rep_a, rep_b;
        int          same;
        t_assign     res;
        n = (m_piu < 1) ? 1 : ((m_piu > NUM_PARTS) ? NUM_PARTS : int'(m_piu));
        best = 0;
        top_score = -65536;
        da = e.degree_a;
        db = e.degree_b;
        rep_a = replica_of(e.vertex_a);
        rep_b = replica_of(e.vertex_b);
        for (int p = 0; p < n; p++) begin
            if (m_load[p] >= m_limit) begin
                sc = -65536;
            end else begin
                s = 0;
                if (rep_a[p]) s += g_term(da, da + db);
                if (rep_b[p]) s += g_term(db, da + db);
                num = (m_largest > m_load[p]) ? 64'(m_largest - m_load[p]) : 64'd0;
                den = (m_largest >= m_smallest) ? 64'd1 + 64'(m_largest - m_smallest) : 64'd1;
                r = (num << 16) / den;
                if (r > (64'd1 << 40)) r = 64'd1 << 40;
                s += (64'(m_weight) * r) >> 12;
                if (s > 64'd4194303) s = 64'd4194303;
                sc = longint'(s);
            end
            if (sc > top_score) begin
                top_score = sc;
                best = p;
            end
        end
        m_replica[e.vertex_a] = replica_of(e.vertex_a) | (16'h1 << best);
        m_replica[e.vertex_b] = replica_of(e.vertex_b) | (16'h1 << best);
        old_ld = m_load[best];
        now_ld = (old_ld == 32'hFFFF_FFFF) ? old_ld : old_ld + 1;
        m_load[best] = now_ld;
        if (now_ld > m_largest) m_largest = now_ld;
        if (old_ld == m_smallest) begin
            same = 0;
            for (int p = 0; p < n; p++)
                if (m_load[p] == m_smallest) same++;
            if (same == 0 && m_smallest != 32'hFFFF_FFFF) m_smallest++;
        end
        res.part = 4'(best);
        res.load = now_ld;
        return res;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        logic nv_edge;
        logic nv_cfg;
        nv_edge = 1'b0;
        nv_cfg  = 1'b0;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            // Retire a transfer taken at this edge.
            if (edge_ch.valid && edge_ch.ready) begin
                assign_q.push_back(predict_edge({edge_ch.vertex_a, edge_ch.vertex_b,
                                                 edge_ch.degree_a, edge_ch.degree_b}));
                void'(pending_q.pop_front());
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_BALANCE_WEIGHT: m_weight = cfg_ch.data[15:0];
                    CFG_LOAD_LIMIT:     m_limit  = cfg_ch.data;
                    CFG_PARTS_IN_USE:   m_piu    = cfg_ch.data[4:0];
                    default: ;
                endcase
                void'(pending_q.pop_front());
            end
            if (edge_ch.valid && !edge_ch.ready) begin
                nv_edge = 1'b1;  // hold until taken
            end else if (cfg_ch.valid && !cfg_ch.ready) begin
                nv_cfg = 1'b1;
            end else if (pending_q.size() > 0) begin
                cur_idle  <= pending_q[0].send_idle;
                cur_stall <= pending_q[0].recv_stall;
                case (pending_q[0].op)
                    OP_DRAIN: begin
                        if (assign_q.size() == 0) begin
                            if (drain_wait >= 100) begin
                                drain_wait = 0;
                                void'(pending_q.pop_front());
                            end else begin
                                drain_wait++;
                            end
                        end
                    end
                    OP_CFG: begin
                        nv_cfg = 1'b1;
                        cfg_ch.index <= pending_q[0].idx;
                        cfg_ch.data  <= pending_q[0].data;
                    end
                    default: begin
                        if ($urandom_range(99) >= pending_q[0].send_idle) begin
                            nv_edge = 1'b1;
                            edge_ch.vertex_a <= pending_q[0].e.vertex_a;
                            edge_ch.vertex_b <= pending_q[0].e.vertex_b;
                            edge_ch.degree_a <= pending_q[0].e.degree_a;
                            edge_ch.degree_b <= pending_q[0].e.degree_b;
                        end
                    end
                endcase
            end
        end
        edge_ch.valid <= nv_edge;
        cfg_ch.valid  <= nv_cfg;
    end

    // Receiver: random stalls at the current phase's rate.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            part_ch.ready <= 1'b0;
        else
            part_ch.ready <= ($urandom_range(99) >= cur_stall);
    end

    // Monitor
    always @(posedge i_clk) begin
        t_assign want;
        if (i_rst_n && part_ch.valid && part_ch.ready) begin
            if (assign_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: part %0d load %0d",
                             part_ch.chosen_part, part_ch.part_load);
            end else begin
                want = assign_q.pop_front();
                if (want.part !== part_ch.chosen_part || want.load !== part_ch.part_load) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected part %0d load %0d, got part %0d load %0d",
                                 want.part, want.load, part_ch.chosen_part, part_ch.part_load);
                end
            end
        end
    end

    int ph_idle;
    int ph_stall;

    task automatic add_edge(input logic [15:0] va, input logic [15:0] vb,
                            input logic [15:0] da, input logic [15:0] db);
        t_pending t;
        t.op = OP_EDGE;
        t.e = '{va, vb, da, db};
        t.send_idle = ph_idle;
        t.recv_stall = ph_stall;
        pending_q.push_back(t);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_pending t;
        t.op = OP_DRAIN;
        t.send_idle = ph_idle;
        t.recv_stall = ph_stall;
        pending_q.push_back(t);
        t.op = OP_CFG;
        t.idx = idx;
        t.data = data;
        pending_q.push_back(t);
    endtask

    task automatic add_random_edges(input int count, input int vspan);
        logic [15:0] va, vb;
        for (int k = 0; k < count; k++) begin
            // Mostly a small vertex pool so replicas build up; sometimes any id.
            va = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(vspan));
            vb = ($urandom_range(7) == 0) ? va : 16'($urandom_range(vspan));
            if ($urandom_range(9) == 0) vb = 16'($urandom);
            add_edge(va, vb, ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                                       : 16'($urandom_range(40, 1)),
                     ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                              : 16'($urandom_range(40, 1)));
        end
    endtask

    initial begin
        m_weight = WEIGHT_RST;
        m_limit = LIMIT_RST;
        m_piu = PIU_RST;
        m_largest = 0;
        m_smallest = 0;
        foreach (m_load[p]) m_load[p] = 0;
        edge_ch.valid = 1'b0;
        edge_ch.vertex_a = '0;
        edge_ch.vertex_b = '0;
        edge_ch.degree_a = '0;
        edge_ch.degree_b = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_BALANCE_WEIGHT;
        cfg_ch.data = '0;
        part_ch.ready = 1'b0;
        ph_idle = 0;
        ph_stall = 0;

        // Directed: default config, field extremes, same vertex twice.
        add_edge(16'h0000, 16'hFFFF, 16'd1, 16'd1);
        add_edge(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_edge(16'h0000, 16'h0000, 16'hFFFF, 16'd1);
        add_edge(16'hFFFF, 16'hAAAA, 16'd1, 16'hFFFF);
        add_edge(16'h5555, 16'h0000, 16'h5555, 16'hAAAA);
        // Zero weight, one partition, then every partition full.
        add_cfg(CFG_BALANCE_WEIGHT, 32'd0);
        add_edge(16'h0000, 16'hFFFF, 16'd3, 16'd5);
        add_cfg(CFG_PARTS_IN_USE, 32'd1);
        add_edge(16'h1234, 16'h4321, 16'd2, 16'd2);
        add_cfg(CFG_PARTS_IN_USE, 32'd0);  // clamps to 1
        add_edge(16'h1234, 16'h1234, 16'd2, 16'd9);
        add_cfg(CFG_LOAD_LIMIT, 32'd0);
        add_cfg(CFG_PARTS_IN_USE, 32'd31); // clamps to 16
        add_edge(16'h0001, 16'h0002, 16'd7, 16'd7);
        add_edge(16'h0003, 16'h0004, 16'd1, 16'd2);
        add_cfg(CFG_LOAD_LIMIT, 32'd3);
        add_cfg(CFG_BALANCE_WEIGHT, 32'hFFFF);
        for (int k = 0; k < 8; k++)
            add_edge(16'(k), 16'(k + 1), 16'd1, 16'd1);
        add_cfg(CFG_LOAD_LIMIT, 32'hFFFF_FFFF);

        // Random phases over several settings; idle rates rotate.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin ph_idle = 0;  ph_stall = 0;  end
                1: begin ph_idle = 63; ph_stall = 0;  end
                2: begin ph_idle = 0;  ph_stall = 63; end
                default: begin ph_idle = 19; ph_stall = 19; end
            endcase
            add_cfg(CFG_BALANCE_WEIGHT, (ph == 3) ? 32'hFFFF : 32'($urandom_range(16384)));
            add_cfg(CFG_PARTS_IN_USE, (ph == 5) ? 32'd16 : 32'($urandom_range(16, 2)));
            add_cfg(CFG_LOAD_LIMIT, (ph % 2) ? 32'hFFFF_FFFF : 32'($urandom_range(60, 4)));
            add_random_edges(100, (ph < 4) ? 63 : 500);
        end

        // Release reset once the stimulus is queued; the clearing pass runs after release.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // End of run and timeout.
    always @(posedge i_clk) begin
        if (i_rst_n && pending_q.size() == 0 && assign_q.size() == 0 && !stim_done)
            stim_done <= 1'b1;
        if (stim_done) begin
            repeat (150) @(posedge i_clk);
            if (errors == 0 && assign_q.size() == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end else if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
